[rtl/voice_spike_detector_core_defines.svh]
// ----------------------------------------------------------------------------
// voice_spike_detector_core_defines
// Assertion helpers shared by the voice spike detector RTL.
// ----------------------------------------------------------------------------
`ifndef VOICE_SPIKE_DETECTOR_CORE_DEFINES_SVH
`define VOICE_SPIKE_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VSD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vsd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vsd assertion failed");

`endif

[rtl/vsd_pkg.sv]
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and constants for the voice spike detector.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W      = 4;

    localparam logic [1:0] CMD_AUDIO  = 2'd0;
    localparam logic [1:0] CMD_WAKE   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] MODE_AUDIO = 2'd0;

    localparam logic [1:0] REG_WAKE_MODE = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_PERIOD    = 2'd2;
    localparam logic [1:0] REG_COOLDOWN  = 2'd3;

    localparam logic [31:0] THRESHOLD_RST = 32'd100000000;
    localparam logic [15:0] PERIOD_RST    = 16'd1000;
    localparam logic [15:0] COOLDOWN_RST  = 16'd2000;

    localparam logic signed [15:0] FRAME_MIN_RST = 16'sh7FFF;
    localparam logic signed [15:0] FRAME_MAX_RST = 16'sh8000;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] sample;
        logic               last_of_frame;
        logic [31:0]        now_ms;
    } vsd_in_t;

    typedef struct packed {
        logic        detected;
        logic        voice_flag;
        logic [31:0] level;
        logic [31:0] baseline;
    } vsd_out_t;

    typedef struct packed {
        logic        shift;
        logic        load;
        logic [31:0] load_data;
    } vsd_cell_ctl_t;

    typedef struct packed {
        logic nz;
        logic lt;
        logic le;
    } vsd_cell_flags_t;

endpackage

[rtl/vsd_cell.sv]
// ----------------------------------------------------------------------------
// vsd_cell
// One entry of the level ring; rotates toward the head and ranks itself
// against the level currently at the head.
// ----------------------------------------------------------------------------
module vsd_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  vsd_pkg::vsd_cell_ctl_t   ctl,
    input  logic [31:0]              nbr_i,
    input  logic [31:0]              cand_i,
    output logic [31:0]              value_o,
    output vsd_pkg::vsd_cell_flags_t flags_o
);
    import vsd_pkg::*;

    logic [31:0] value_reg;
    logic [31:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.shift) begin
            value_next = nbr_i;
        end else if (ctl.load) begin
            value_next = ctl.load_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value_o    = value_reg;
    assign flags_o.nz = (value_reg != '0);
    assign flags_o.lt = (value_reg != '0) && (value_reg < cand_i);
    assign flags_o.le = (value_reg != '0) && (value_reg <= cand_i);

endmodule

[rtl/voice_spike_detector_core.sv]
// ----------------------------------------------------------------------------
// voice_spike_detector_core
// Peak-to-peak voice detector with a percentile baseline kept in a ring of cells.
// ----------------------------------------------------------------------------
// Results are registered: a result appears the cycle after accept, or, when a
// frame end updates the baseline ring, after the ring has rotated in ST_PASS.
// Throughput: one word per cycle while the result side keeps up; a baseline
// update holds the input off while the ring rotates once.
// Reset (aresetn low, synchronous) restores registers and clears the ring.
module voice_spike_detector_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  vsd_pkg::vsd_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output vsd_pkg::vsd_out_t             m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vsd_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import vsd_pkg::*;
    `include "voice_spike_detector_core_defines.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PASS = 1'b1;

    logic               st_reg, st_next;
    logic [1:0]         mode_reg;
    logic [31:0]        thr_reg;
    logic [15:0]        period_reg, cool_reg;
    logic signed [15:0] fmin_reg, fmin_next, fmax_reg, fmax_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [31:0]        base_reg, base_next, lvl_reg, lvl_next;
    logic [31:0]        upd_reg, upd_next, cend_reg, cend_next;
    logic               flag_reg, flag_next;
    logic [PTR_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]        now_reg, now_next, found_reg, found_next;
    logic               mval_reg, mval_next;
    vsd_out_t           mdata_reg, mdata_next;

    vsd_cell_ctl_t      ctl   [STORE_DEPTH];
    logic [31:0]        val   [STORE_DEPTH];
    vsd_cell_flags_t    flags [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] nz_v, lt_v, le_v;

    logic               shift;
    logic               load;
    logic [31:0]        load_data;

    // ------------------------------------------------------------------
    // Cell ring: cell i takes its neighbor's value, so entries rotate
    // through cell 0, which serves as the ranking candidate.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
            assign ctl[gi].shift     = shift;
            assign ctl[gi].load      = load && (ptr_reg == PTR_W'(gi));
            assign ctl[gi].load_data = load_data;
            vsd_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl[gi]),
                .nbr_i   (val[(gi + 1) % STORE_DEPTH]),
                .cand_i  (val[0]),
                .value_o (val[gi]),
                .flags_o (flags[gi])
            );
            assign nz_v[gi] = flags[gi].nz;
            assign lt_v[gi] = flags[gi].lt;
            assign le_v[gi] = flags[gi].le;
        end
    endgenerate

    // Head value sits at sorted position k when fewer than k+1 entries are
    // below it and more than k entries are at or below it.
    logic [CNT_W-1:0] n_cnt, lt_cnt, le_cnt, k_idx;
    logic [CNT_W+1:0] n3;
    logic             head_hit;

    assign n_cnt    = CNT_W'($countones(nz_v));
    assign lt_cnt   = CNT_W'($countones(lt_v));
    assign le_cnt   = CNT_W'($countones(le_v));
    assign n3       = (CNT_W+2)'(n_cnt) * (CNT_W+2)'(3);
    assign k_idx    = n3[CNT_W+1:2];
    assign head_hit = (val[0] != '0) && (lt_cnt <= k_idx) && (le_cnt > k_idx);

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_WAKE_MODE: prdata = {30'd0, mode_reg};
            REG_THRESHOLD: prdata = thr_reg;
            REG_PERIOD:    prdata = {16'd0, period_reg};
            REG_COOLDOWN:  prdata = {16'd0, cool_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_AUDIO;
            thr_reg    <= THRESHOLD_RST;
            period_reg <= PERIOD_RST;
            cool_reg   <= COOLDOWN_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_WAKE_MODE: mode_reg   <= pwdata[1:0];
                REG_THRESHOLD: thr_reg    <= pwdata;
                REG_PERIOD:    period_reg <= pwdata[15:0];
                REG_COOLDOWN:  cool_reg   <= pwdata[15:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Item processing
    // ------------------------------------------------------------------
    logic               acc;
    logic signed [15:0] smin, smax;
    logic signed [16:0] span;
    logic [31:0]        lvl_new, elapsed, dec_lvl, dec_base, dec_now, base_final;
    logic               in_cool, frame_go, upd_go, det, dec_go;
    logic [32:0]        twice_base;

    assign s_ready  = (st_reg == ST_IDLE) && (!mval_reg || m_ready);
    assign acc      = s_valid && s_ready;
    assign smin     = (s_data.sample < fmin_reg) ? s_data.sample : fmin_reg;
    assign smax     = (s_data.sample > fmax_reg) ? s_data.sample : fmax_reg;
    assign span     = 17'(smax) - 17'(smin);
    assign lvl_new  = {span[15:0], 16'd0};
    assign in_cool  = s_data.now_ms < cend_reg;
    assign elapsed  = s_data.now_ms - upd_reg;
    assign frame_go = s_data.last_of_frame && (mode_reg == MODE_AUDIO) && !in_cool;
    assign upd_go   = frame_go && (elapsed >= {16'd0, period_reg});

    assign base_final = head_hit ? val[0] : found_reg;
    assign dec_lvl    = (st_reg == ST_PASS) ? lvl_reg : lvl_new;
    assign dec_base   = (st_reg == ST_PASS) ? base_final : base_reg;
    assign dec_now    = (st_reg == ST_PASS) ? now_reg : s_data.now_ms;
    assign twice_base = {dec_base, 1'b0};
    assign det        = dec_go && (dec_lvl > thr_reg) &&
                        ((dec_base == '0) || ({1'b0, dec_lvl} > twice_base));

    always_comb begin
        st_next    = st_reg;
        fmin_next  = fmin_reg;
        fmax_next  = fmax_reg;
        ptr_next   = ptr_reg;
        base_next  = base_reg;
        lvl_next   = lvl_reg;
        upd_next   = upd_reg;
        cend_next  = cend_reg;
        flag_next  = flag_reg;
        cnt_next   = cnt_reg;
        now_next   = now_reg;
        found_next = found_reg;
        mval_next  = mval_reg && !m_ready;
        mdata_next = mdata_reg;
        shift      = 1'b0;
        load       = 1'b0;
        load_data  = lvl_new;
        dec_go     = 1'b0;

        unique case (st_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_data.command == CMD_AUDIO) begin
                        if (s_data.last_of_frame) begin
                            fmin_next = FRAME_MIN_RST;
                            fmax_next = FRAME_MAX_RST;
                        end else begin
                            fmin_next = smin;
                            fmax_next = smax;
                        end
                        if (frame_go) begin
                            lvl_next = lvl_new;
                            dec_go   = !upd_go;
                        end
                    end else if (s_data.command == CMD_WAKE) begin
                        dec_go = 1'b0;
                    end else if (s_data.command == CMD_CLEAR) begin
                        flag_next = 1'b0;
                    end
                    if (upd_go && s_data.command == CMD_AUDIO) begin
                        load       = 1'b1;
                        ptr_next   = (ptr_reg == PTR_W'(STORE_DEPTH - 1)) ?
                                     '0 : ptr_reg + PTR_W'(1);
                        upd_next   = s_data.now_ms;
                        now_next   = s_data.now_ms;
                        found_next = '0;
                        cnt_next   = '0;
                        st_next    = ST_PASS;
                    end else begin
                        if (det || (s_data.command == CMD_WAKE && !in_cool)) begin
                            flag_next = 1'b1;
                            cend_next = s_data.now_ms + {16'd0, cool_reg};
                        end
                        mval_next             = 1'b1;
                        mdata_next.detected   = det ||
                                                (s_data.command == CMD_WAKE && !in_cool);
                        mdata_next.voice_flag = (s_data.command == CMD_CLEAR) ? 1'b0 :
                                                (det || (s_data.command == CMD_WAKE &&
                                                 !in_cool)) ? 1'b1 : flag_reg;
                        mdata_next.level      = (s_data.command == CMD_AUDIO && frame_go) ?
                                                lvl_new : lvl_reg;
                        mdata_next.baseline   = base_reg;
                    end
                end
            end
            ST_PASS: begin
                shift    = 1'b1;
                cnt_next = cnt_reg + PTR_W'(1);
                if (head_hit) begin
                    found_next = val[0];
                end
                if (cnt_reg == PTR_W'(STORE_DEPTH - 1)) begin
                    dec_go    = 1'b1;
                    base_next = base_final;
                    st_next   = ST_IDLE;
                    if (det) begin
                        flag_next = 1'b1;
                        cend_next = dec_now + {16'd0, cool_reg};
                    end
                    mval_next             = 1'b1;
                    mdata_next.detected   = det;
                    mdata_next.voice_flag = det ? 1'b1 : flag_reg;
                    mdata_next.level      = lvl_reg;
                    mdata_next.baseline   = base_final;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            fmin_reg  <= FRAME_MIN_RST;
            fmax_reg  <= FRAME_MAX_RST;
            ptr_reg   <= '0;
            base_reg  <= '0;
            lvl_reg   <= '0;
            upd_reg   <= '0;
            cend_reg  <= '0;
            flag_reg  <= 1'b0;
            cnt_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            st_reg    <= st_next;
            fmin_reg  <= fmin_next;
            fmax_reg  <= fmax_next;
            ptr_reg   <= ptr_next;
            base_reg  <= base_next;
            lvl_reg   <= lvl_next;
            upd_reg   <= upd_next;
            cend_reg  <= cend_next;
            flag_reg  <= flag_next;
            cnt_reg   <= cnt_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg   <= now_next;
        found_reg <= found_next;
        mdata_reg <= mdata_next;
    end

    assign m_valid = mval_reg;
    assign m_data  = mdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `VSD_ASSERT_NOW(a_no_accept_in_pass, aclk, aresetn, st_reg == ST_PASS, !s_ready)
    `VSD_ASSERT_NOW(a_detect_sets_flag, aclk, aresetn,
        m_valid && m_data.detected, m_data.voice_flag)
    `VSD_ASSERT_NEXT(a_pass_ends_in_result, aclk, aresetn,
        st_reg == ST_PASS && cnt_reg == PTR_W'(STORE_DEPTH - 1), m_valid && st_reg == ST_IDLE)
    `VSD_ASSERT_NEXT(a_update_starts_pass, aclk, aresetn,
        acc && s_data.command == CMD_AUDIO && upd_go, st_reg == ST_PASS && cnt_reg == '0)

endmodule
